### rtl/partial_permutation_table_unit_assert.svh
// Assertion macros used by the RTL.
`ifndef PARTIAL_PERMUTATION_TABLE_UNIT_ASSERT_SVH
`define PARTIAL_PERMUTATION_TABLE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define PPT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PPT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/ppt_pkg.sv
`default_nettype none

package ppt_pkg;

  localparam int MaxPositions = 16;
  localparam int PosWidth     = 4;
  localparam int ValWidth     = 4;
  localparam int DimWidth     = 5;

  // Operation codes
  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpSet   = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  // Error codes
  localparam logic [1:0] ErrOk    = 2'd0;
  localparam logic [1:0] ErrIndex = 2'd1;
  localparam logic [1:0] ErrDup   = 2'd2;

  // Read value reported for an unset position or an error (-1)
  localparam logic [4:0] UnsetCode = 5'h1F;

  // Register byte addresses
  localparam logic [1:0] AddrDimension = 2'd0;

  localparam logic [DimWidth-1:0] DimReset = 5'd16;

  typedef struct packed {
    logic [DimWidth-1:0] least_unused;
    logic                complete;
    logic [DimWidth-1:0] unset_count;
    logic [1:0]          error_code;
    logic [4:0]          read_value;
  } result_t;

endpackage

`default_nettype wire

### rtl/partial_permutation_table_unit.sv
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tuser: opcode; s_tdata: position, value
//  m_        out  m_tvalid/m_tready  m_tdata: read_value, error_code,
//                                    unset_count, complete, least_unused
//  apb       in   psel/penable       dimension register at byte address 0
//
//  Each transaction reads the map memory at the addressed position, then in
//  the execute state checks, writes back and loads the result register.
//  Accept the next input once the previous one has left the execute cycle.
//  Reset (rst, synchronous) clears the valid bits, the bitmap and the count of
//  values >= dim, and sets dimension and the unset count to 16; a stalled
//  output holds the execute cycle.
`default_nettype none
`include "partial_permutation_table_unit_assert.svh"

module partial_permutation_table_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [3:0] position, [7:4] value
  input  wire logic [1:0]  s_tuser,   // [1:0] opcode
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [4:0] read_value, [6:5] error_code,
                                      // [11:7] unset_count, [12] complete,
                                      // [17:13] least_unused, [23:18] zero
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ppt_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EXEC = 1'b1;

  logic [0:0] state;

  // Control and summary state
  logic [DimWidth-1:0]     dim;
  logic [MaxPositions-1:0] valid;
  logic [15:0]             used;
  logic [DimWidth-1:0]     unset_cnt;
  logic [DimWidth-1:0]     big_cnt;     // valid entries holding a value >= dim

  // Latched transaction
  logic [1:0]          op_r;
  logic [PosWidth-1:0] pos_r;
  logic [ValWidth-1:0] val_r;

  // Map memory: value of each position, qualified by valid
  logic [ValWidth-1:0] map_mem [MaxPositions];
  logic [ValWidth-1:0] mem_rdata;
  logic                mem_we;
  logic [PosWidth-1:0] mem_waddr;
  logic [ValWidth-1:0] mem_wdata;

  // Execute-cycle next values
  logic [MaxPositions-1:0] valid_next;
  logic [15:0]             used_next;
  logic [DimWidth-1:0]     unset_cnt_next;
  logic [DimWidth-1:0]     big_cnt_next;
  logic                    exec_we;
  result_t                 res;

  logic accept, fire, cfg_wr;
  logic [DimWidth-1:0] dim_wr;

  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign fire     = (state == ST_EXEC) && (!m_tvalid || m_tready);
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr == AddrDimension);

  // Clamp the written dimension into 1..16
  always_comb begin
    if (pwdata[DimWidth-1:0] == '0) begin
      dim_wr = DimWidth'(1);
    end else if (pwdata[DimWidth-1:0] > DimWidth'(MaxPositions)) begin
      dim_wr = DimWidth'(MaxPositions);
    end else begin
      dim_wr = pwdata[DimWidth-1:0];
    end
  end

  always_comb begin
    if (paddr == AddrDimension) begin
      prdata = {{(32-DimWidth){1'b0}}, dim};
    end else begin
      prdata = '0;
    end
  end

  // Execute: check, update bitmap and counters, build the result
  always_comb begin
    logic                vld;
    logic                in_range;
    logic                dup;
    logic                old_big;
    logic                new_big;
    logic [DimWidth-1:0] least;

    vld      = valid[pos_r];
    in_range = {1'b0, pos_r} < dim;
    dup      = used[val_r] && !(vld && (mem_rdata == val_r));
    old_big  = vld && ({1'b0, mem_rdata} >= dim);
    new_big  = {1'b0, val_r} >= dim;

    valid_next     = valid;
    used_next      = used;
    unset_cnt_next = unset_cnt;
    big_cnt_next   = big_cnt;
    exec_we        = 1'b0;
    res.error_code = ErrOk;
    res.read_value = UnsetCode;

    case (op_r)
      OpSet: begin
        if (dup) begin
          res.error_code = ErrDup;
        end else if (!in_range) begin
          res.error_code = ErrIndex;
        end else begin
          // release the old value, then claim the new one
          if (vld) begin
            used_next[mem_rdata] = 1'b0;
          end else begin
            unset_cnt_next = unset_cnt - DimWidth'(1);
          end
          used_next[val_r]  = 1'b1;
          valid_next[pos_r] = 1'b1;
          big_cnt_next      = big_cnt - DimWidth'(old_big) + DimWidth'(new_big);
          exec_we           = 1'b1;
          res.read_value    = {1'b0, val_r};
        end
      end
      OpClear: begin
        if (!in_range) begin
          res.error_code = ErrIndex;
        end else begin
          if (vld) begin
            used_next[mem_rdata] = 1'b0;
            unset_cnt_next       = unset_cnt + DimWidth'(1);
            big_cnt_next         = big_cnt - DimWidth'(old_big);
          end
          valid_next[pos_r] = 1'b0;
        end
      end
      default: begin
        if (!in_range) begin
          res.error_code = ErrIndex;
        end else if (vld) begin
          res.read_value = {1'b0, mem_rdata};
        end
      end
    endcase

    // least value not held: first clear bit of the bitmap, 16 when full
    least = DimWidth'(16);
    for (int i = 15; i >= 0; i--) begin
      if (!used_next[i]) begin
        least = DimWidth'(i);
      end
    end

    res.unset_count  = unset_cnt_next;
    res.complete     = (unset_cnt_next == '0) && (big_cnt_next == '0);
    res.least_unused = least;
  end

  // Memory write port: a config write of dimension one seeds entry zero
  always_comb begin
    if (cfg_wr) begin
      mem_we    = (dim_wr == DimWidth'(1));
      mem_waddr = '0;
      mem_wdata = '0;
    end else begin
      mem_we    = fire && exec_we;
      mem_waddr = pos_r;
      mem_wdata = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_rdata <= map_mem[s_tdata[PosWidth-1:0]];
    end
  end

  // Latch the transaction on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= s_tuser;
      pos_r <= s_tdata[PosWidth-1:0];
      val_r <= s_tdata[PosWidth +: ValWidth];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (accept) begin
      state <= ST_EXEC;
    end else if (fire) begin
      state <= ST_IDLE;
    end
  end

  // Table state: reset and config writes reinitialise, execute commits
  always_ff @(posedge clk) begin
    if (rst) begin
      dim       <= DimReset;
      valid     <= '0;
      used      <= '0;
      unset_cnt <= DimReset;
      big_cnt   <= '0;
    end else if (cfg_wr) begin
      dim     <= dim_wr;
      big_cnt <= '0;
      if (dim_wr == DimWidth'(1)) begin
        // position zero holds value zero
        valid     <= MaxPositions'(1);
        used      <= 16'd1;
        unset_cnt <= '0;
      end else begin
        valid     <= '0;
        used      <= '0;
        unset_cnt <= dim_wr;
      end
    end else if (fire) begin
      valid     <= valid_next;
      used      <= used_next;
      unset_cnt <= unset_cnt_next;
      big_cnt   <= big_cnt_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {6'd0, res};
    end
  end

  // The number of valid entries matches the number of values marked in the bitmap
  `PPT_ASSERT_IMPL(a_bitmap_matches, clk, rst, 1'b1, $countones(valid) == $countones(used))
  // Unset positions never exceed the dimension
  `PPT_ASSERT_IMPL(a_unset_bound, clk, rst, 1'b1, unset_cnt <= dim)
  // An accepted transaction moves to the execute cycle
  `PPT_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == ST_EXEC)
  // A completed execute cycle presents a result
  `PPT_ASSERT_NEXT(a_fire_result, clk, rst, fire, m_tvalid && (state == ST_IDLE))

endmodule

`default_nettype wire
